FILE: design/w3mf_pkg.sv
// Shared types and constants of the 3x3 mean and median window filter.
// Used by the channel interfaces and the filter top level; no dependencies.
package w3mf_pkg;

    localparam int PIXEL_W     = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int SUM_W       = 12;
    localparam int RECIP_W     = 13;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int MEAN_SHIFT  = 16;

    // Reciprocal of nine scaled by two to the sixteenth, rounded up; exact for sums of nine pixels.
    localparam logic [RECIP_W-1:0] MEAN_RECIP = 13'd7282;

    typedef logic [PIXEL_W-1:0] t_pixel;

    typedef struct packed {
        t_pixel top;
        t_pixel mid;
        t_pixel bot;
    } t_column;

    typedef struct packed {
        t_pixel lo;
        t_pixel md;
        t_pixel hi;
    } t_trio;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FILTER_MODE  = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2
    } t_cfg_index;

endpackage

FILE: design/w3mf_in_if.sv
// Input pixel channel of the window filter: valid, ready and one pixel or pad per beat.
// Depends on w3mf_pkg for the pixel type.
interface w3mf_in_if;
    import w3mf_pkg::*;

    logic   valid;
    logic   ready;
    t_pixel pixel_in;
    logic   pad;

    modport source (output valid, output pixel_in, output pad, input ready);
    modport sink   (input valid, input pixel_in, input pad, output ready);
endinterface

FILE: design/w3mf_out_if.sv
// Result channel of the window filter: valid, ready and one filtered pixel per beat.
// Depends on w3mf_pkg for the pixel type.
interface w3mf_out_if;
    import w3mf_pkg::*;

    logic   valid;
    logic   ready;
    t_pixel pixel_out;
    logic   frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

FILE: design/window_3x3_mean_median_filter.sv
// 3x3 mean or median filter over a raster stream of 8-bit grey pixels, with edge pixels
// replicated at the borders; it uses w3mf_pkg and the w3mf_in_if and w3mf_out_if channels.
// The block takes one beat per clock cycle unless the result side stalls it; each result passes
// through stages 1 to 3 and the output register after the beat that completes its window. The
// rate is set by the two line memories, read and written at one column per beat. A frame of
// W by H pixels is followed by W+1 pad beats, its last result carries frame_last, and results
// start after one row plus two pixels. The line memories need no clearing pass after reset.
// Writing the frame width or height restarts the frame; configure only while the block is idle.
module window_3x3_mean_median_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    w3mf_in_if.sink                         i_pix,
    w3mf_out_if.source                      o_pix,
    input  logic                            i_cfg_we,
    input  logic [w3mf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [w3mf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import w3mf_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 2);
    localparam int RST_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int RST_H = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

    function automatic t_trio sort3(input t_pixel a, input t_pixel b, input t_pixel c);
        t_pixel lo1;
        t_pixel hi1;
        t_trio  res;
        lo1 = (a < b) ? a : b;
        hi1 = (a < b) ? b : a;
        if (c <= lo1) begin
            res.lo = c;
            res.md = lo1;
            res.hi = hi1;
        end else if (c >= hi1) begin
            res.lo = lo1;
            res.md = hi1;
            res.hi = c;
        end else begin
            res.lo = lo1;
            res.md = c;
            res.hi = hi1;
        end
        return res;
    endfunction

    // Configuration, held as effective (saturated) values.
    logic          r_mode;
    logic [WW-1:0] r_w;
    logic [HW-1:0] r_h;

    // Frame position counters.
    logic [CW-1:0] r_in_col, n_in_col;
    logic [RW-1:0] r_in_row, n_in_row;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [RW-1:0] r_out_row, n_out_row;

    // Line memories; even rows go to the first, odd rows to the second.
    t_pixel r_mem0 [MAX_WIDTH];
    t_pixel r_mem1 [MAX_WIDTH];
    t_pixel r_rd0;
    t_pixel r_rd1;

    logic   w_in_acc;
    logic   w_en_o, w_en3, w_en2, w_en1;
    logic   w_restart;
    logic   w_emit, w_last, w_store;
    t_pixel w_cur;

    // Stage 1: accepted beat.
    logic   r_s1_valid;
    t_pixel r_s1_cur;
    logic   r_s1_par, r_s1_top_clamp, r_s1_bot_clamp;
    logic   r_s1_emit, r_s1_last, r_s1_left, r_s1_right;

    // Column history of the window.
    t_column r_col1, r_col2;
    t_column w_col_new;
    t_pixel  w_mid_raw, w_top_raw;

    // Stage 2: the nine window pixels.
    logic    r_s2_valid, r_s2_last;
    t_column r_s2_left, r_s2_cent, r_s2_right;

    // Stage 3: median candidates and the window sum.
    logic             r_s3_valid, r_s3_last;
    t_pixel           r_s3_lo, r_s3_md, r_s3_hi;
    logic [SUM_W-1:0] r_s3_sum;

    t_trio            w_row_top, w_row_mid, w_row_bot;
    t_trio            w_los, w_mds, w_his;
    logic [SUM_W-1:0] w_sum;
    logic [PROD_W-1:0] w_prod;
    t_trio            w_final;

    // Output register.
    logic   r_o_valid, r_o_last;
    t_pixel r_o_pixel;

    assign w_in_acc    = i_pix.valid && i_pix.ready;
    assign w_en_o      = !r_o_valid || o_pix.ready;
    assign w_en3       = !r_s3_valid || w_en_o;
    assign w_en2       = !r_s2_valid || w_en3;
    assign w_en1       = !r_s1_valid || w_en2;
    assign i_pix.ready = w_en1;

    assign w_restart = i_cfg_we && ((i_cfg_index == CFG_FRAME_WIDTH)
                                 || (i_cfg_index == CFG_FRAME_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
            r_w    <= WW'(RST_W);
            r_h    <= HW'(RST_H);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FILTER_MODE: begin
                    r_mode <= i_cfg_data[0];
                end
                CFG_FRAME_WIDTH: begin
                    if (i_cfg_data == '0) begin
                        r_w <= WW'(1);
                    end else if (32'(i_cfg_data) > 32'(MAX_WIDTH)) begin
                        r_w <= WW'(MAX_WIDTH);
                    end else begin
                        r_w <= WW'(i_cfg_data);
                    end
                end
                CFG_FRAME_HEIGHT: begin
                    if (i_cfg_data == '0) begin
                        r_h <= HW'(1);
                    end else if (32'(i_cfg_data) > 32'(MAX_HEIGHT)) begin
                        r_h <= HW'(MAX_HEIGHT);
                    end else begin
                        r_h <= HW'(i_cfg_data);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_cur   = i_pix.pad ? '0 : i_pix.pixel_in;
        w_store = r_in_row < RW'(r_h);
        w_emit  = (r_in_row >= RW'(2)) || ((r_in_row == RW'(1)) && (r_in_col != '0));
        w_last  = w_emit && (r_out_row == RW'(r_h) - RW'(1))
                         && (WW'(r_out_col) == r_w - WW'(1));

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (w_last) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else begin
            if (w_emit) begin
                if (WW'(r_out_col) == r_w - WW'(1)) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + RW'(1);
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
            end
            if (WW'(r_in_col) == r_w - WW'(1)) begin
                n_in_col = '0;
                if (r_in_row < RW'(r_h) + RW'(1)) begin
                    n_in_row = r_in_row + RW'(1);
                end
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (w_restart) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (w_in_acc) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_rd0 <= r_mem0[r_in_col];
            if (w_store && !r_in_row[0]) begin
                r_mem0[r_in_col] <= w_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_rd1 <= r_mem1[r_in_col];
            if (w_store && r_in_row[0]) begin
                r_mem1[r_in_col] <= w_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en1) begin
            r_s1_valid <= w_in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_cur       <= w_cur;
            r_s1_par       <= r_in_row[0];
            r_s1_top_clamp <= r_in_row == RW'(1);
            r_s1_bot_clamp <= !w_store;
            r_s1_emit      <= w_emit;
            r_s1_last      <= w_last;
            r_s1_left      <= r_out_col == '0;
            r_s1_right     <= WW'(r_out_col) == r_w - WW'(1);
        end
    end

    always_comb begin
        w_mid_raw     = r_s1_par ? r_rd0 : r_rd1;
        w_top_raw     = r_s1_par ? r_rd1 : r_rd0;
        w_col_new.mid = w_mid_raw;
        w_col_new.top = r_s1_top_clamp ? w_mid_raw : w_top_raw;
        w_col_new.bot = r_s1_bot_clamp ? w_mid_raw : r_s1_cur;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && w_en2) begin
            r_col1     <= r_col2;
            r_col2     <= w_col_new;
            r_s2_left  <= r_s1_left ? r_col2 : r_col1;
            r_s2_cent  <= r_col2;
            r_s2_right <= r_s1_right ? r_col2 : w_col_new;
            r_s2_last  <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en2) begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
        end
    end

    always_comb begin
        w_row_top = sort3(r_s2_left.top, r_s2_cent.top, r_s2_right.top);
        w_row_mid = sort3(r_s2_left.mid, r_s2_cent.mid, r_s2_right.mid);
        w_row_bot = sort3(r_s2_left.bot, r_s2_cent.bot, r_s2_right.bot);
        w_los     = sort3(w_row_top.lo, w_row_mid.lo, w_row_bot.lo);
        w_mds     = sort3(w_row_top.md, w_row_mid.md, w_row_bot.md);
        w_his     = sort3(w_row_top.hi, w_row_mid.hi, w_row_bot.hi);
        w_sum     = SUM_W'(r_s2_left.top) + SUM_W'(r_s2_cent.top) + SUM_W'(r_s2_right.top)
                  + SUM_W'(r_s2_left.mid) + SUM_W'(r_s2_cent.mid) + SUM_W'(r_s2_right.mid)
                  + SUM_W'(r_s2_left.bot) + SUM_W'(r_s2_cent.bot) + SUM_W'(r_s2_right.bot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_en3) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3 && r_s2_valid) begin
            r_s3_lo   <= w_los.hi;
            r_s3_md   <= w_mds.md;
            r_s3_hi   <= w_his.lo;
            r_s3_sum  <= w_sum;
            r_s3_last <= r_s2_last;
        end
    end

    always_comb begin
        w_prod  = PROD_W'(r_s3_sum) * PROD_W'(MEAN_RECIP);
        w_final = sort3(r_s3_lo, r_s3_md, r_s3_hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en_o) begin
            r_o_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_o && r_s3_valid) begin
            r_o_pixel <= r_mode ? w_final.md : w_prod[MEAN_SHIFT +: PIXEL_W];
            r_o_last  <= r_s3_last;
        end
    end

    assign o_pix.valid      = r_o_valid;
    assign o_pix.pixel_out  = r_o_pixel;
    assign o_pix.frame_last = r_o_last;

endmodule

FILE: tb/filter_check_pkg.sv
`timescale 1ns / 100ps
// Result checker for the 3x3 mean and median window filter testbench: it predicts each
// filtered pixel from the accepted input beats and compares the results in order.
// Depends on w3mf_pkg for the pixel type, the register indexes and the register width.
package filter_check_pkg;
    import w3mf_pkg::*;

    localparam int unsigned FRAME_MAX   = 1024;
    localparam int unsigned HISTORY_LEN = 2 * FRAME_MAX + 4;
    localparam int unsigned WINDOW_SIZE = 9;

    typedef struct packed {
        t_pixel pixel;
        logic   last;
    } t_filtered;

    class filter_scoreboard;
        logic                  median_sel;
        logic [CFG_DATA_W-1:0] width_reg;
        logic [CFG_DATA_W-1:0] height_reg;
        t_pixel                history [HISTORY_LEN];
        int unsigned           in_col;
        int unsigned           in_row;
        int unsigned           out_col;
        int unsigned           out_row;
        t_filtered             filtered_q [$];
        int                    errors;

        function new();
            median_sel = 1'b1;
            width_reg  = CFG_DATA_W'(FRAME_MAX);
            height_reg = CFG_DATA_W'(FRAME_MAX);
            foreach (history[i]) history[i] = '0;
            errors = 0;
            restart();
        endfunction

        function void restart();
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        function int unsigned saturate(logic [CFG_DATA_W-1:0] value);
            if (value == 0) return 1;
            if (value > FRAME_MAX) return FRAME_MAX;
            return value;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_FILTER_MODE: begin
                    median_sel = data[0];
                end
                CFG_FRAME_WIDTH: begin
                    width_reg = data;
                    restart();
                end
                CFG_FRAME_HEIGHT: begin
                    height_reg = data;
                    restart();
                end
                default: begin
                end
            endcase
        endfunction

        function void note_beat(t_pixel pixel_in, logic pad);
            int unsigned w;
            int unsigned h;
            int unsigned lin_in;
            int unsigned lin_out;
            int unsigned sum;
            int unsigned below;
            int unsigned upto;
            int          rs;
            int          cs;
            int          k;
            int          j;
            t_pixel      px;
            t_pixel      win [WINDOW_SIZE];
            t_pixel      mid;
            t_filtered   res;

            w       = saturate(width_reg);
            h       = saturate(height_reg);
            lin_in  = in_row * w + in_col;
            lin_out = out_row * w + out_col;
            px      = pad ? '0 : pixel_in;
            if (lin_in < w * h) history[lin_in % HISTORY_LEN] = px;

            if (out_row < h && lin_in >= lin_out + w + 1) begin
                sum = 0;
                mid = '0;
                for (k = 0; k < WINDOW_SIZE; k++) begin
                    rs = int'(out_row) + k / 3 - 1;
                    cs = int'(out_col) + k % 3 - 1;
                    if (rs < 0) rs = 0;
                    if (rs > int'(h) - 1) rs = int'(h) - 1;
                    if (cs < 0) cs = 0;
                    if (cs > int'(w) - 1) cs = int'(w) - 1;
                    win[k] = history[(int'(rs) * w + int'(cs)) % HISTORY_LEN];
                    sum += win[k];
                end
                for (k = 0; k < WINDOW_SIZE; k++) begin
                    below = 0;
                    upto  = 0;
                    for (j = 0; j < WINDOW_SIZE; j++) begin
                        if (win[j] < win[k]) below++;
                        if (win[j] <= win[k]) upto++;
                    end
                    if (below <= WINDOW_SIZE / 2 && upto > WINDOW_SIZE / 2) mid = win[k];
                end
                res.pixel = median_sel ? mid : t_pixel'(sum / WINDOW_SIZE);
                res.last  = (out_row == h - 1) && (out_col == w - 1);
                filtered_q.push_back(res);
                if (res.last) begin
                    restart();
                    return;
                end
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row++;
                end
            end

            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                if (in_row < h + 1) in_row++;
            end
        endfunction

        function void check_result(t_pixel pixel_out, logic frame_last);
            t_filtered want;
            if (filtered_q.size() == 0) begin
                errors++;
                $display("%0t: result with none outstanding: expected nothing, actual %0d last %0b",
                         $time, pixel_out, frame_last);
                return;
            end
            want = filtered_q.pop_front();
            if (pixel_out !== want.pixel) begin
                errors++;
                $display("%0t: pixel_out mismatch: expected %0d, actual %0d",
                         $time, want.pixel, pixel_out);
            end
            if (frame_last !== want.last) begin
                errors++;
                $display("%0t: frame_last mismatch: expected %0b, actual %0b",
                         $time, want.last, frame_last);
            end
        endfunction

        function int outstanding();
            return filtered_q.size();
        endfunction
    endclass

endpackage

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Top level of the window filter testbench: clock, reset, the beat drivers of both channels,
// register writes and the directed and random frames. Depends on w3mf_pkg, the two channel
// interfaces, filter_check_pkg and window_3x3_mean_median_filter.
module tb_top;
    import w3mf_pkg::*;
    import filter_check_pkg::*;

    localparam int TARGET_BEATS  = 1850;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_PCT      = 7;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    logic                   i_clk     = 1'b0;
    logic                   i_rst_n   = 1'b0;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   steady    = 1'b0;
    logic                   hold_req  = 1'b0;
    logic                   hold_done = 1'b0;
    int                     hold_count  = 0;
    int                     cycle_count = 0;
    int                     beats_sent  = 0;

    w3mf_in_if  pix_in ();
    w3mf_out_if pix_out ();

    filter_scoreboard sb = new();

    window_3x3_mean_median_filter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_in),
        .o_pix       (pix_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // The result side takes beats at random, or always when steady, except for one long hold-off.
    always @(posedge i_clk) begin
        if (i_rst_n && pix_out.valid && pix_out.ready)
            sb.check_result(pix_out.pixel_out, pix_out.frame_last);
        if (hold_req && !hold_done) begin
            pix_out.ready <= 1'b0;
            hold_count    <= hold_count + 1;
            if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
        end else begin
            pix_out.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic send_beat(input t_pixel px, input logic pad);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            pix_in.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.pixel_in <= px;
        pix_in.pad      <= pad;
        @(posedge i_clk);
        while (!pix_in.ready) @(posedge i_clk);
        sb.note_beat(px, pad);
        beats_sent++;
    endtask

    task automatic drain();
        pix_in.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(index, data);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] mode_data,
                             input logic [CFG_DATA_W-1:0] width_data,
                             input logic [CFG_DATA_W-1:0] height_data);
        write_reg(CFG_FILTER_MODE, mode_data);
        write_reg(CFG_FRAME_WIDTH, width_data);
        write_reg(CFG_FRAME_HEIGHT, height_data);
        cfg_we <= 1'b0;
    endtask

    function automatic t_pixel random_pixel();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        if (pick < 4) return t_pixel'($urandom_range(100, 103));
        return t_pixel'($urandom);
    endfunction

    // Pixels of the frame first, then the flush beats; pads inside the frame and pixels
    // among the flush beats are mixed in at random.
    task automatic send_frame(input int unsigned w, input int unsigned h,
                              input int unsigned beats);
        int unsigned n;
        for (n = 0; n < beats; n++) begin
            if (n < w * h)
                send_beat(random_pixel(), $urandom_range(99) < 3);
            else
                send_beat(random_pixel(), $urandom_range(99) >= 20);
        end
    endtask

    initial begin
        int unsigned           n;
        int unsigned           w;
        int unsigned           h;
        int unsigned           len;
        int unsigned           phase;
        logic [CFG_DATA_W-1:0] wd;
        logic [CFG_DATA_W-1:0] hd;

        pix_in.valid    <= 1'b0;
        pix_in.pixel_in <= '0;
        pix_in.pad      <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_FILTER_MODE;
        cfg_data        <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A 3x3 frame in the median mode left from reset, on a checkerboard of extremes.
        write_reg(CFG_FRAME_WIDTH, 11'd3);
        write_reg(CFG_FRAME_HEIGHT, 11'd3);
        cfg_we <= 1'b0;
        for (n = 0; n < 9; n++) send_beat(n[0] ? 8'd255 : 8'd0, 1'b0);
        for (n = 0; n < 4; n++) send_beat(8'd255, 1'b1);
        drain();

        // Zero width and height saturate to a single pixel; the mean of nine copies of 255.
        configure(11'd0, 11'd0, 11'd0);
        send_beat(8'd255, 1'b0);
        send_beat(8'd0, 1'b1);
        send_beat(8'd0, 1'b1);
        drain();

        // A 2x2 median frame with a pad inside it, switched to the mean part way through.
        configure(11'd1, 11'd2, 11'd2);
        send_beat(8'd0, 1'b0);
        send_beat(8'd255, 1'b1);
        send_beat(8'd255, 1'b0);
        send_beat(8'd17, 1'b0);
        send_beat(8'd0, 1'b1);
        drain();
        write_reg(CFG_FILTER_MODE, 11'h7FE);
        cfg_we <= 1'b0;
        send_beat(8'd99, 1'b0);
        send_beat(8'd0, 1'b1);
        drain();

        write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;

        // Widest and tallest settings, each cut short by the next register write.
        configure(CFG_DATA_W'($urandom), 11'h7FF, 11'd1);
        send_frame(FRAME_MAX, 1, FRAME_MAX + 6);
        drain();
        configure(CFG_DATA_W'($urandom), 11'd3, 11'h7FF);
        send_frame(3, FRAME_MAX, 40);
        drain();

        // The sender offers beats without a gap while the result side holds off.
        configure(CFG_DATA_W'($urandom), 11'd32, 11'd12);
        hold_req <= 1'b1;
        steady   <= 1'b1;
        send_frame(32, 12, 32 * 12 + 33);
        drain();

        wd    = '0;
        hd    = '0;
        phase = 0;
        while (beats_sent < TARGET_BEATS) begin
            steady <= (phase >= 10 && phase < 25);
            if (phase != 0 && $urandom_range(9) == 0) begin
                write_reg(CFG_FILTER_MODE, CFG_DATA_W'($urandom));
                cfg_we <= 1'b0;
            end else begin
                n = $urandom_range(99);
                if (n < 75)
                    wd = CFG_DATA_W'($urandom_range(1, 10));
                else if (n < 95)
                    wd = CFG_DATA_W'($urandom_range(11, 40));
                else
                    wd = CFG_DATA_W'($urandom_range(41, 96));
                if ($urandom_range(99) < 80)
                    hd = CFG_DATA_W'($urandom_range(1, 6));
                else
                    hd = CFG_DATA_W'($urandom_range(7, 16));
                configure(CFG_DATA_W'($urandom), wd, hd);
            end
            w   = sb.saturate(wd);
            h   = sb.saturate(hd);
            len = w * h + w + 1;
            if ($urandom_range(99) < 12) len = $urandom_range(1, len - 1);
            send_frame(w, h, len);
            drain();
            phase++;
        end

        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

FILE: window_3x3_mean_median_filter.f
design/w3mf_pkg.sv
design/w3mf_in_if.sv
design/w3mf_out_if.sv
design/window_3x3_mean_median_filter.sv
tb/filter_check_pkg.sv
tb/tb_top.sv
